[rtl/rtom_pkg.sv]
// shared types, field widths, codes and defaults for the rectangle tile occupancy map
package rtom_pkg;

    // default geometry and owner id width
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;
    localparam int DEF_ID_BITS  = 16;

    // port field widths
    localparam int FUNC_W    = 3;
    localparam int POS_W     = 8;
    localparam int SIZE_W    = 7;
    localparam int OWNER_W   = 16;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // signed width for corner arithmetic: covers -512 .. 511
    localparam int COORD_W = 10;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_RESERVE     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RESERVE_SAFE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CHECK       = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR_RECT  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR_OWNER = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLEAR_ALL   = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // what a scan does with each tile
    typedef enum logic [1:0] {
        MD_FILL,
        MD_PROBE,
        MD_CLEAR
    } t_mode;

endpackage

[rtl/rtom_ram.sv]
// simple dual-port tile memory, one write and one registered read per cycle
module rtom_ram #(
    parameter int ADDR_BITS = 12,
    parameter int DATA_BITS = 17
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rect_tile_occupancy_map_unit.sv]
// top level of the rectangle tile occupancy map: request sequencer around the tile memory
//
// Every tile of the grid sits in one memory word (a taken bit and an owner id) at
// row-major address {row, column}, and each request walks its tiles through that
// memory at one tile per cycle, so cost follows the number of tiles walked. A reserve
// writes each tile of its rectangle; check, clear_rect and clear_owner read each tile
// and then pass through a drain state for the last read; reserve_safe reads each tile
// and, when none is taken, walks the rectangle again to write it. clear_owner walks
// the whole grid and clear_all writes the whole memory. Reserve, reserve_safe and check
// requests that fail the bounds test or have an empty rectangle, clear_rect requests
// whose clamped corners cross, and requests with an unused code skip the walk.
// After reset the block runs a clearing pass over the whole memory during which it
// stalls input; configuration writes are taken at any time.
// One request is worked at a time; a finished result waits in the output register while
// the next request is already accepted.
module rect_tile_occupancy_map_unit
    import rtom_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int ID_BITS  = DEF_ID_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic signed [POS_W-1:0]     i_pos_x,
    input  logic signed [POS_W-1:0]     i_pos_y,
    input  logic [SIZE_W-1:0]           i_rect_w,
    input  logic [SIZE_W-1:0]           i_rect_h,
    input  logic [OWNER_W-1:0]          i_owner_id,
    input  logic                        i_use_ignore,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_ok,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    localparam int COL_BITS  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_BITS  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_BITS = COL_BITS + ROW_BITS;
    localparam int WORD_BITS = ID_BITS + 1;

    localparam logic [COL_BITS-1:0] COL_LAST = '1;
    localparam logic [ROW_BITS-1:0] ROW_LAST = '1;

    // effective grid dimension: zero acts as one, clipped to the array size
    function automatic logic signed [COORD_W-1:0] eff_dim(
        input logic [CFG_W-1:0] reg_val,
        input int unsigned      max_val
    );
        logic [COORD_W-1:0] ext;
        logic [COORD_W-1:0] lim;
        ext = COORD_W'(reg_val);
        lim = COORD_W'(max_val);
        if (reg_val == '0) begin
            return COORD_W'(1);
        end else if (ext > lim) begin
            return signed'(lim);
        end
        return signed'(ext);
    endfunction

    // clamp a coordinate into 0 .. hi
    function automatic logic signed [COORD_W-1:0] clamp_pos(
        input logic signed [COORD_W-1:0] v,
        input logic signed [COORD_W-1:0] hi
    );
        if (v < 0) begin
            return '0;
        end else if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] r_grid_w;
    logic [CFG_W-1:0] r_grid_h;

    // control state
    t_state r_state, n_state;
    logic   r_pend, n_pend;
    logic   r_out_valid, n_out_valid;
    logic [COL_BITS-1:0] r_cx, n_cx;
    logic [ROW_BITS-1:0] r_cy, n_cy;

    // request payload held during the walk
    t_mode               r_mode, n_mode;
    logic [COL_BITS-1:0] r_x0, n_x0, r_x1, n_x1;
    logic [ROW_BITS-1:0] r_y0, n_y0, r_y1, n_y1;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic                r_ign, n_ign;
    logic                r_safe, n_safe;
    logic                r_hit, n_hit;
    logic                r_ok, n_ok;
    logic                r_out_ok, n_out_ok;
    logic [WORD_BITS-1:0] r_wdata, n_wdata;
    logic [ADDR_BITS-1:0] r_pend_addr, n_pend_addr;

    // memory port signals
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // request decode
    logic signed [COORD_W-1:0] px, py, ex, ey, gw, gh;
    logic signed [COORD_W-1:0] csx, csy, cex, cey;
    logic                      in_bounds;
    logic                      rect_empty;
    logic                      clr_empty;
    logic [ID_BITS-1:0]        req_id;

    // tile read back
    logic               rd_taken;
    logic [ID_BITS-1:0] rd_id;
    logic               probe_hit;
    logic               clr_match;
    logic               hit_now;
    logic               scan_last;

    rtom_ram #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (WORD_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= CFG_W'(1);
            r_grid_h <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_WIDTH:  r_grid_w <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_h <= i_cfg_data;
                default:         r_grid_w <= r_grid_w;
            endcase
        end
    end

    // corner arithmetic and bounds for the incoming request
    always_comb begin
        px         = COORD_W'(i_pos_x);
        py         = COORD_W'(i_pos_y);
        ex         = px + signed'(COORD_W'(i_rect_w)) - COORD_W'(1);
        ey         = py + signed'(COORD_W'(i_rect_h)) - COORD_W'(1);
        gw         = eff_dim(r_grid_w, MAX_COLS);
        gh         = eff_dim(r_grid_h, MAX_ROWS);
        in_bounds  = (px >= 0) && (py >= 0) && (ex < gw) && (ey < gh);
        rect_empty = (i_rect_w == '0) || (i_rect_h == '0);
        csx        = clamp_pos(px, gw - COORD_W'(1));
        cex        = clamp_pos(ex, gw - COORD_W'(1));
        csy        = clamp_pos(py, gh - COORD_W'(1));
        cey        = clamp_pos(ey, gh - COORD_W'(1));
        clr_empty  = (cex < csx) || (cey < csy);
        req_id     = ID_BITS'(i_owner_id);
    end

    // tile word from last cycle's read
    always_comb begin
        rd_taken  = mem_rdata[ID_BITS];
        rd_id     = mem_rdata[ID_BITS-1:0];
        probe_hit = rd_taken && !(r_ign && (rd_id == r_id));
        clr_match = rd_taken && (rd_id == r_id);
        hit_now   = r_hit || (r_pend && probe_hit);
        scan_last = (r_cx == r_x1) && (r_cy == r_y1);
    end

    // sequencer: next state, memory ports and result
    always_comb begin
        n_state     = r_state;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_mode      = r_mode;
        n_x0        = r_x0;
        n_x1        = r_x1;
        n_y0        = r_y0;
        n_y1        = r_y1;
        n_id        = r_id;
        n_ign       = r_ign;
        n_safe      = r_safe;
        n_hit       = r_hit;
        n_ok        = r_ok;
        n_wdata     = r_wdata;
        n_pend_addr = r_pend_addr;

        mem_we    = 1'b0;
        mem_waddr = {r_cy, r_cx};
        mem_wdata = r_wdata;
        mem_re    = 1'b0;
        mem_raddr = {r_cy, r_cx};

        // result beat taken downstream
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        // finish the tile read issued last cycle
        if (r_pend) begin
            if (r_mode == MD_PROBE && probe_hit) begin
                n_hit = 1'b1;
            end
            if (r_mode == MD_CLEAR && clr_match) begin
                mem_we    = 1'b1;
                mem_waddr = r_pend_addr;
                mem_wdata = '0;
            end
        end

        unique case (r_state)
            // clearing pass over the whole memory after reset
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = {r_cy, r_cx};
                mem_wdata = '0;
                if (r_cx == COL_LAST) begin
                    n_cx = '0;
                    n_cy = r_cy + ROW_BITS'(1);
                    if (r_cy == ROW_LAST) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_cx = r_cx + COL_BITS'(1);
                end
            end

            // take a request and set up its walk
            ST_IDLE: begin
                if (i_valid) begin
                    n_id    = req_id;
                    n_ign   = 1'b0;
                    n_safe  = 1'b0;
                    n_hit   = 1'b0;
                    n_ok    = 1'b0;
                    n_mode  = MD_FILL;
                    n_wdata = {1'b1, req_id};
                    n_x0    = COL_BITS'(px);
                    n_x1    = COL_BITS'(ex);
                    n_y0    = ROW_BITS'(py);
                    n_y1    = ROW_BITS'(ey);
                    n_state = ST_DONE;
                    unique case (i_func)
                        FN_RESERVE: begin
                            n_ok = in_bounds;
                            if (in_bounds && !rect_empty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_RESERVE_SAFE: begin
                            n_ok   = in_bounds;
                            n_mode = MD_PROBE;
                            n_safe = 1'b1;
                            if (in_bounds && !rect_empty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_CHECK: begin
                            n_ok   = !in_bounds;
                            n_mode = MD_PROBE;
                            n_ign  = i_use_ignore;
                            if (in_bounds && !rect_empty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_CLEAR_RECT: begin
                            n_ok   = 1'b1;
                            n_mode = MD_CLEAR;
                            n_x0   = COL_BITS'(csx);
                            n_x1   = COL_BITS'(cex);
                            n_y0   = ROW_BITS'(csy);
                            n_y1   = ROW_BITS'(cey);
                            if (!clr_empty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        FN_CLEAR_OWNER: begin
                            n_ok    = 1'b1;
                            n_mode  = MD_CLEAR;
                            n_x0    = '0;
                            n_x1    = COL_BITS'(gw - COORD_W'(1));
                            n_y0    = '0;
                            n_y1    = ROW_BITS'(gh - COORD_W'(1));
                            n_state = ST_SCAN;
                        end
                        FN_CLEAR_ALL: begin
                            n_ok    = 1'b1;
                            n_wdata = '0;
                            n_x0    = '0;
                            n_x1    = COL_LAST;
                            n_y0    = '0;
                            n_y1    = ROW_LAST;
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                    n_cx = n_x0;
                    n_cy = n_y0;
                end
            end

            // one tile per cycle, row by row
            ST_SCAN: begin
                if (r_mode == MD_FILL) begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_cy, r_cx};
                    mem_wdata = r_wdata;
                end else begin
                    mem_re      = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = {r_cy, r_cx};
                end
                if (r_cx == r_x1) begin
                    n_cx = r_x0;
                    n_cy = r_cy + ROW_BITS'(1);
                end else begin
                    n_cx = r_cx + COL_BITS'(1);
                end
                if (scan_last) begin
                    n_state = (r_mode == MD_FILL) ? ST_DONE : ST_DRAIN;
                end
            end

            // last read settles; a free safe reserve goes on to write
            ST_DRAIN: begin
                n_state = ST_DONE;
                if (r_mode == MD_PROBE) begin
                    n_ok = r_safe ? !hit_now : hit_now;
                    if (r_safe && !hit_now) begin
                        n_mode  = MD_FILL;
                        n_cx    = r_x0;
                        n_cy    = r_y0;
                        n_state = ST_SCAN;
                    end
                end
            end

            // hand the result to the output register once it is free
            ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_ok    = r_ok;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cx        <= '0;
            r_cy        <= '0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_x0        <= n_x0;
        r_x1        <= n_x1;
        r_y0        <= n_y0;
        r_y1        <= n_y1;
        r_id        <= n_id;
        r_ign       <= n_ign;
        r_safe      <= n_safe;
        r_hit       <= n_hit;
        r_ok        <= n_ok;
        r_out_ok    <= n_out_ok;
        r_wdata     <= n_wdata;
        r_pend_addr <= n_pend_addr;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_ok    = r_out_ok;

endmodule

[rtl/rtom_checker.sv]
// port-level checks for the rectangle tile occupancy map, bound to the top level
module rtom_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_ok
);

    // reset empties the result register
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a held result beat keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ok))
        else $error("stalled result changed");

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("request accepted while previous one in flight");

    // no result beat can appear in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> !$rose(o_valid))
        else $error("result appeared too early");

endmodule

bind rect_tile_occupancy_map_unit rtom_checker u_rtom_checker (.*);

[tb/tb_rect_tile_occupancy_map_unit.sv]
// self-checking testbench for the rectangle tile occupancy map: tile-grid predictor, driver, monitor
module tb_rect_tile_occupancy_map_unit;
    import rtom_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_COUNT      = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int RAND_BLOCKS     = 8;
    localparam int ITEMS_PER_BLOCK = 100;
    localparam int HOLD_CYCLES     = 600;
    localparam int END_SETTLE      = 100;
    localparam int MAX_PRINTS      = 40;
    // worst case: about 830 beats, each a full-grid reserve_safe;
    // the limit sits about three times above that
    localparam int CYCLE_LIMIT     = 20_000_000;

    // codes the block does not define
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [SIZE_W-1:0]       rect_w;
        logic [SIZE_W-1:0]       rect_h;
        logic [OWNER_W-1:0]      owner_id;
        logic                    use_ignore;
    } t_req;

    // dut ports
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_valid      = 1'b0;
    logic                    o_stall;
    logic [FUNC_W-1:0]       i_func       = '0;
    logic signed [POS_W-1:0] i_pos_x      = '0;
    logic signed [POS_W-1:0] i_pos_y      = '0;
    logic [SIZE_W-1:0]       i_rect_w     = '0;
    logic [SIZE_W-1:0]       i_rect_h     = '0;
    logic [OWNER_W-1:0]      i_owner_id   = '0;
    logic                    i_use_ignore = 1'b0;
    logic                    o_valid;
    logic                    i_stall      = 1'b0;
    logic                    o_ok;
    logic                    i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx    = '0;
    logic [CFG_W-1:0]        i_cfg_data   = '0;

    // predicted tile grid and grid size registers
    bit                   tile_taken [TILE_COUNT];
    bit [DEF_ID_BITS-1:0] tile_owner [TILE_COUNT];
    logic [CFG_W-1:0]     grid_w_reg = 7'd1;
    logic [CFG_W-1:0]     grid_h_reg = 7'd1;

    // traffic bookkeeping
    t_req req_pending [$];
    bit   ok_expected [$];
    t_req cur_req;
    bit   ok_want;
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    int   hold_asked   = 0;
    int   hold_given   = 0;
    int   hold_left    = 0;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   cycle_count  = 0;

    rect_tile_occupancy_map_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_rect_w     (i_rect_w),
        .i_rect_h     (i_rect_h),
        .i_owner_id   (i_owner_id),
        .i_use_ignore (i_use_ignore),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ok         (o_ok),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // register value to grid size in use
    function automatic int dim_of(logic [CFG_W-1:0] r, int maxv);
        if (r == 0) return 1;
        if (int'(r) > maxv) return maxv;
        return int'(r);
    endfunction

    function automatic int clamp_to(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // any tile of the rectangle taken, tiles of the ignored owner aside
    function automatic bit area_taken(int x0, int y0, int x1, int y1, bit ign,
                                      bit [DEF_ID_BITS-1:0] id);
        int x, y, idx;
        bit hit;
        hit = 1'b0;
        for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
                idx = y * DEF_MAX_COLS + x;
                if (tile_taken[idx] && !(ign && tile_owner[idx] == id)) hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void fill_area(int x0, int y0, int x1, int y1, bit [DEF_ID_BITS-1:0] id);
        int x, y;
        for (y = y0; y <= y1; y++) begin
            for (x = x0; x <= x1; x++) begin
                tile_taken[y * DEF_MAX_COLS + x] = 1'b1;
                tile_owner[y * DEF_MAX_COLS + x] = id;
            end
        end
    endfunction

    // empty the tiles of one owner between the corners clamped to the grid
    function automatic void clear_owned(int x0, int y0, int x1, int y1, int gw, int gh,
                                        bit [DEF_ID_BITS-1:0] id);
        int sx, sy, ex, ey, x, y, idx;
        sx = clamp_to(x0, gw - 1);
        sy = clamp_to(y0, gh - 1);
        ex = clamp_to(x1, gw - 1);
        ey = clamp_to(y1, gh - 1);
        for (y = sy; y <= ey; y++) begin
            for (x = sx; x <= ex; x++) begin
                idx = y * DEF_MAX_COLS + x;
                if (tile_taken[idx] && tile_owner[idx] == id) begin
                    tile_taken[idx] = 1'b0;
                    tile_owner[idx] = '0;
                end
            end
        end
    endfunction

    // update the predicted grid for one accepted request and return its ok bit
    function automatic bit apply_request(t_req r);
        int gw, gh, x0, y0, x1, y1, i;
        bit fits, ok;
        bit [DEF_ID_BITS-1:0] id;
        gw   = dim_of(grid_w_reg, DEF_MAX_COLS);
        gh   = dim_of(grid_h_reg, DEF_MAX_ROWS);
        x0   = int'(r.pos_x);
        y0   = int'(r.pos_y);
        x1   = x0 + int'(r.rect_w) - 1;
        y1   = y0 + int'(r.rect_h) - 1;
        id   = r.owner_id[DEF_ID_BITS-1:0];
        fits = x0 >= 0 && y0 >= 0 && x1 < gw && y1 < gh;
        ok   = 1'b0;
        case (r.func)
            FN_RESERVE: begin
                if (fits) fill_area(x0, y0, x1, y1, id);
                ok = fits;
            end
            FN_RESERVE_SAFE: begin
                if (fits && !area_taken(x0, y0, x1, y1, 1'b0, '0)) begin
                    fill_area(x0, y0, x1, y1, id);
                    ok = 1'b1;
                end
            end
            FN_CHECK: begin
                ok = !fits || area_taken(x0, y0, x1, y1, r.use_ignore, id);
            end
            FN_CLEAR_RECT: begin
                clear_owned(x0, y0, x1, y1, gw, gh, id);
                ok = 1'b1;
            end
            FN_CLEAR_OWNER: begin
                clear_owned(0, 0, gw - 1, gh - 1, gw, gh, id);
                ok = 1'b1;
            end
            FN_CLEAR_ALL: begin
                for (i = 0; i < TILE_COUNT; i++) begin
                    tile_taken[i] = 1'b0;
                    tile_owner[i] = '0;
                end
                ok = 1'b1;
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic void queue_request(logic [FUNC_W-1:0] f, int px, int py, int w, int h,
                                          logic [OWNER_W-1:0] id, logic ign);
        t_req r;
        r.func       = f;
        r.pos_x      = px[POS_W-1:0];
        r.pos_y      = py[POS_W-1:0];
        r.rect_w     = w[SIZE_W-1:0];
        r.rect_h     = h[SIZE_W-1:0];
        r.owner_id   = id;
        r.use_ignore = ign;
        req_pending.push_back(r);
    endfunction

    // owners mostly from a small pool so that clears and ignores hit
    function automatic logic [OWNER_W-1:0] pick_owner();
        logic [31:0] raw;
        raw = $urandom();
        if ($urandom_range(99) >= 85) return raw[OWNER_W-1:0];
        case ($urandom_range(4))
            0: return 16'h0001;
            1: return 16'h00A5;
            2: return 16'h7FFF;
            3: return 16'hFFFF;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        int sel;
        sel = $urandom_range(99);
        if (sel < 26) return FN_RESERVE;
        if (sel < 52) return FN_RESERVE_SAFE;
        if (sel < 78) return FN_CHECK;
        if (sel < 90) return FN_CLEAR_RECT;
        if (sel < 96) return FN_CLEAR_OWNER;
        if (sel < 98) return FN_CLEAR_ALL;
        return ($urandom_range(1) != 0) ? FN_SPARE_7 : FN_SPARE_6;
    endfunction

    // mostly rectangles that fit, some near the edges, some fully random
    function automatic void queue_random_request(int gw, int gh);
        int shape, px, py, rw, rh;
        logic [31:0] raw;
        shape = $urandom_range(99);
        raw   = $urandom();
        if (shape < 72) begin
            rw = ($urandom_range(99) < 4) ? $urandom_range(1, gw)
                                          : $urandom_range(1, (gw < 6) ? gw : 6);
            rh = ($urandom_range(99) < 4) ? $urandom_range(1, gh)
                                          : $urandom_range(1, (gh < 6) ? gh : 6);
            px = $urandom_range(0, gw - rw);
            py = $urandom_range(0, gh - rh);
        end else if (shape < 90) begin
            rw = $urandom_range(0, 8);
            rh = $urandom_range(0, 8);
            px = int'($urandom_range(0, gw + 4)) - 3;
            py = int'($urandom_range(0, gh + 4)) - 3;
        end else begin
            px = int'(raw[7:0]);
            py = int'(raw[15:8]);
            rw = int'(raw[22:16]);
            rh = int'(raw[29:23]);
        end
        queue_request(pick_func(), px, py, rw, rh, pick_owner(), 1'($urandom_range(1)));
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < MAX_PRINTS)
            $display("ERROR %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (req_pending.size() != 0 || i_valid || ok_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // grid size writes, only while the block is idle
    task automatic set_grid(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_GRID_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GRID_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
        grid_w_reg = w;
        grid_h_reg = h;
    endtask

    // request driver: predicts each accepted beat, then loads the next one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) ok_expected.push_back(apply_request(cur_req));
            if (!i_valid || !o_stall) begin
                if (req_pending.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_req = req_pending.pop_front();
                    i_func       <= cur_req.func;
                    i_pos_x      <= cur_req.pos_x;
                    i_pos_y      <= cur_req.pos_y;
                    i_rect_w     <= cur_req.rect_w;
                    i_rect_h     <= cur_req.rect_h;
                    i_owner_id   <= cur_req.owner_id;
                    i_use_ignore <= cur_req.use_ignore;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result stall: random idling or a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            i_stall    <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_given + 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (ok_expected.size() == 0) begin
                flag_mismatch("result beat with nothing expected", int'(o_ok), 0);
            end else begin
                ok_want = ok_expected.pop_front();
                if (o_ok !== ok_want) flag_mismatch("ok", int'(o_ok), int'(ok_want));
            end
            results_seen++;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rect_tile_occupancy_map_unit: mismatch");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        int blk, n, gw, gh;
        logic [CFG_W-1:0] cw, ch;
        tx_idle_pct = 12;
        rx_idle_pct = 56;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset grid of one tile
        queue_request(FN_RESERVE,      0, 0, 1, 1, 16'h0001, 1'b0);
        queue_request(FN_CHECK,        0, 0, 1, 1, 16'h0000, 1'b0);
        queue_request(FN_CHECK,        0, 0, 1, 1, 16'h0001, 1'b1);
        queue_request(FN_RESERVE_SAFE, 0, 0, 1, 1, 16'h0002, 1'b0);
        queue_request(FN_RESERVE,      0, 0, 2, 1, 16'h0002, 1'b0);
        queue_request(FN_SPARE_6,      0, 0, 1, 1, 16'h0001, 1'b0);
        queue_request(FN_SPARE_7,   -128, 127, 127, 0, 16'hFFFF, 1'b1);
        // zero-size clear far outside still clamps onto the edge tile
        queue_request(FN_CLEAR_RECT, -128, -128, 0, 0, 16'h0001, 1'b0);
        queue_request(FN_CHECK,        0, 0, 1, 1, 16'h0000, 1'b0);
        wait_idle();

        // zero size registers act as one
        set_grid(7'd0, 7'd0);
        queue_request(FN_RESERVE,      0, 0, 0, 0, 16'hFFFF, 1'b0);
        queue_request(FN_CHECK,       -1, 0, 1, 1, 16'h0000, 1'b0);
        wait_idle();

        // oversize registers act as the full grid
        set_grid(7'd127, 7'd127);
        queue_request(FN_RESERVE,      0, 0, 64, 64, 16'hFFFF, 1'b0);
        queue_request(FN_RESERVE_SAFE, 60, 60, 4, 4, 16'h0001, 1'b0);
        queue_request(FN_CHECK,        0, 0, 64, 64, 16'hFFFF, 1'b1);
        queue_request(FN_CLEAR_OWNER,  0, 0, 1, 1, 16'h1234, 1'b0);
        queue_request(FN_CLEAR_RECT,   127, 127, 127, 127, 16'hFFFF, 1'b0);
        queue_request(FN_CHECK,        63, 63, 1, 1, 16'h0000, 1'b0);
        queue_request(FN_CLEAR_OWNER,  0, 0, 1, 1, 16'hFFFF, 1'b0);
        queue_request(FN_RESERVE_SAFE, 60, 60, 4, 4, 16'h5A5A, 1'b0);
        queue_request(FN_RESERVE,      61, 0, 4, 1, 16'h5A5A, 1'b0);
        queue_request(FN_CHECK,        63, -128, 1, 127, 16'h0000, 1'b0);
        // zero-width clear: clamped last corner lies before the first
        queue_request(FN_CLEAR_RECT,   10, 10, 0, 5, 16'h5A5A, 1'b0);
        queue_request(FN_CLEAR_ALL,    0, 0, 1, 1, 16'h0000, 1'b0);
        queue_request(FN_CHECK,        60, 60, 4, 4, 16'h0000, 1'b0);
        queue_request(FN_CHECK,        0, 0, 0, 0, 16'h0000, 1'b0);

        // random blocks, each under its own grid size and idling pattern
        for (blk = 0; blk < RAND_BLOCKS; blk++) begin
            wait_idle();
            case (blk)
                0: begin cw = 7'd64;  ch = 7'd64;  end
                1: begin cw = 7'd8;   ch = 7'd5;   end
                2: begin cw = 7'd0;   ch = 7'd3;   end
                3: begin cw = 7'd127; ch = 7'd1;   end
                4: begin cw = 7'd1;   ch = 7'd127; end
                5: begin cw = 7'd20;  ch = 7'd33;  end
                default: begin
                    cw = 7'($urandom_range(0, 127));
                    ch = 7'($urandom_range(0, 127));
                end
            endcase
            set_grid(cw, ch);
            if (blk < 3) begin
                tx_idle_pct = 12;
                rx_idle_pct = 56;
            end else if (blk < 6) begin
                tx_idle_pct = 56;
                rx_idle_pct = 12;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            gw = dim_of(cw, DEF_MAX_COLS);
            gh = dim_of(ch, DEF_MAX_ROWS);
            for (n = 0; n < ITEMS_PER_BLOCK; n++) queue_random_request(gw, gh);
            // long result hold-off while beats keep coming, so the input backs up
            if (blk == 6) hold_asked = hold_asked + 1;
        end

        wait_idle();
        repeat (END_SETTLE) @(negedge i_clk);
        if (ok_expected.size() != 0) flag_mismatch("results never seen", 0, ok_expected.size());
        if (mismatches == 0) begin
            $display("rect_tile_occupancy_map_unit: match");
        end else begin
            $display("rect_tile_occupancy_map_unit: mismatch");
        end
        $finish;
    end

endmodule
